/* sv/wsp_pkg.sv */
// Shared types, codes and constants of the wheel speed PID duty block.
package wsp_pkg;

   // Fixed-point default: fraction bits of a speed value
   localparam int SPEED_FRAC_BITS_DEF = 8;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DESIRED_SPEED   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PROP       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_INT_DT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_DER_PER_DT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_NUMERATOR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERFLOW_TICKS  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PWM_TOP         = 3'd6;

   // Configuration reset values
   localparam logic [15:0] DESIRED_SPEED_RST   = 16'd0;
   localparam logic [23:0] GAIN_PROP_RST       = 24'd32768;
   localparam logic [23:0] GAIN_INT_DT_RST     = 24'd393;
   localparam logic [23:0] GAIN_DER_PER_DT_RST = 24'd327680;
   localparam logic [23:0] SPEED_NUMERATOR_RST = 24'd15079645;
   localparam logic [15:0] OVERFLOW_TICKS_RST  = 16'd1562;
   localparam logic [15:0] PWM_TOP_RST         = 16'd400;

   // Event codes of an input item
   localparam logic [1:0] OP_CAPTURE  = 2'd0;
   localparam logic [1:0] OP_OVERFLOW = 2'd1;
   localparam logic [1:0] OP_REGULATE = 2'd2;

   // Result kinds
   localparam logic RK_SPEED = 1'b0;
   localparam logic RK_DUTY  = 1'b1;

   // Shared multiplier operand selection
   localparam logic [2:0] MUL_NONE   = 3'd0;
   localparam logic [2:0] MUL_PERIOD = 3'd1;
   localparam logic [2:0] MUL_PROP   = 3'd2;
   localparam logic [2:0] MUL_INT    = 3'd3;
   localparam logic [2:0] MUL_DER    = 3'd4;
   localparam logic [2:0] MUL_SCALE  = 3'd5;

   // Period divider: one quotient bit per cycle over the numerator width
   localparam int DIV_STEPS = 24;
   localparam int DIV_CNT_W = 5;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;        // latch the accepted item
      logic       ovf_inc;     // saturating overflow count
      logic [2:0] mul_sel;     // multiplier operands
      logic       period_load; // period = product + capture
      logic       div_init;
      logic       div_step;
      logic       err_calc;    // error, sum, difference; clear accumulator
      logic       acc_add;     // accumulate product
      logic       commit_cap;  // update speed state, load speed result
      logic       commit_reg;  // update PID state, load duty result
   } wsp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic period_zero;
      logic div_last;
      logic rsp_busy;
   } wsp_sts_type;

endpackage

/* sv/wsp_ctrl.sv */
// Controller state machine sequencing capture, overflow and regulator items.
module wsp_ctrl import wsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_op,
   output logic        req_stall,
   input  wsp_sts_type sts,
   output wsp_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CAP_MUL  = 4'd1;
   localparam logic [3:0] ST_CAP_ADD  = 4'd2;
   localparam logic [3:0] ST_DIV_INIT = 4'd3;
   localparam logic [3:0] ST_DIV      = 4'd4;
   localparam logic [3:0] ST_CAP_DONE = 4'd5;
   localparam logic [3:0] ST_REG_ERR  = 4'd6;
   localparam logic [3:0] ST_REG_MP   = 4'd7;
   localparam logic [3:0] ST_REG_MI   = 4'd8;
   localparam logic [3:0] ST_REG_MD   = 4'd9;
   localparam logic [3:0] ST_REG_ACC  = 4'd10;
   localparam logic [3:0] ST_REG_SCL  = 4'd11;
   localparam logic [3:0] ST_REG_DONE = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Items are taken only between sequences
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_op)
                  OP_CAPTURE:  state_in = ST_CAP_MUL;
                  OP_OVERFLOW: cmd.ovf_inc = 1'b1;
                  OP_REGULATE: state_in = ST_REG_ERR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_CAP_MUL: begin
            cmd.mul_sel = MUL_PERIOD;
            state_in    = ST_CAP_ADD;
         end
         ST_CAP_ADD: begin
            cmd.period_load = 1'b1;
            state_in        = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            if (sts.period_zero) begin
               state_in = ST_CAP_DONE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CAP_DONE;
            end
         end
         ST_CAP_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.commit_cap = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_REG_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = ST_REG_MP;
         end
         ST_REG_MP: begin
            cmd.mul_sel = MUL_PROP;
            state_in    = ST_REG_MI;
         end
         ST_REG_MI: begin
            cmd.mul_sel = MUL_INT;
            cmd.acc_add = 1'b1;
            state_in    = ST_REG_MD;
         end
         ST_REG_MD: begin
            cmd.mul_sel = MUL_DER;
            cmd.acc_add = 1'b1;
            state_in    = ST_REG_ACC;
         end
         ST_REG_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_REG_SCL;
         end
         ST_REG_SCL: begin
            cmd.mul_sel = MUL_SCALE;
            state_in    = ST_REG_DONE;
         end
         ST_REG_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.commit_reg = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/wsp_dp.sv */
// Datapath: configuration, state, shared multiplier, period divider, result register.
module wsp_dp import wsp_pkg::*; #(
   parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [15:0]            req_capture_count,
   input  wsp_cmd_type            cmd,
   output wsp_sts_type            sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [31:0]            rsp_period_ticks,
   output logic [15:0]            rsp_speed_value,
   output logic                   rsp_zero_period,
   output logic [15:0]            rsp_duty_compare
);

   localparam int OUT_SHIFT = SPEED_FRAC_BITS + 16;

   // Configuration registers
   logic [15:0] desired_ff;
   logic [23:0] gain_prop_ff;
   logic [23:0] gain_int_ff;
   logic [23:0] gain_der_ff;
   logic [23:0] numer_ff;
   logic [15:0] ovf_ticks_ff;
   logic [15:0] pwm_top_ff;

   // Block state
   logic [15:0]        ovf_count_ff;
   logic [15:0]        speed_now_ff;
   logic signed [31:0] err_sum_ff;
   logic signed [16:0] last_err_ff;

   // Working registers
   logic [15:0]           cap_ff;
   logic [31:0]           period_ff;
   logic [31:0]           period_in;
   logic [31:0]           rem_ff;
   logic [23:0]           quo_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic signed [16:0]    err_ff;
   logic signed [31:0]    sum_ff;
   logic signed [17:0]    diff_ff;
   logic signed [58:0]    acc_ff;
   logic signed [58:0]    acc_in;
   logic signed [57:0]    prod_ff;
   logic signed [57:0]    prod_in;

   // Result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        rsp_kind_ff;
   logic [31:0] rsp_period_ff;
   logic [15:0] rsp_speed_ff;
   logic        rsp_zero_ff;
   logic [15:0] rsp_duty_ff;

   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic [33:0]        trial;
   logic signed [16:0] err_w;
   logic signed [32:0] sum_w;
   logic signed [31:0] sum_sat;
   logic signed [17:0] diff_w;
   logic [15:0]        speed_calc;
   logic               ge_one;
   logic               le_zero;
   logic [15:0]        duty_calc;

   // Configuration writes; values masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff   <= DESIRED_SPEED_RST;
         gain_prop_ff <= GAIN_PROP_RST;
         gain_int_ff  <= GAIN_INT_DT_RST;
         gain_der_ff  <= GAIN_DER_PER_DT_RST;
         numer_ff     <= SPEED_NUMERATOR_RST;
         ovf_ticks_ff <= OVERFLOW_TICKS_RST;
         pwm_top_ff   <= PWM_TOP_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DESIRED_SPEED:   desired_ff   <= csr_wdata[15:0];
            CSR_GAIN_PROP:       gain_prop_ff <= csr_wdata;
            CSR_GAIN_INT_DT:     gain_int_ff  <= csr_wdata;
            CSR_GAIN_DER_PER_DT: gain_der_ff  <= csr_wdata;
            CSR_SPEED_NUMERATOR: numer_ff     <= csr_wdata;
            CSR_OVERFLOW_TICKS:  ovf_ticks_ff <= csr_wdata[15:0];
            CSR_PWM_TOP:         pwm_top_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_PERIOD: begin
            mul_a = {17'd0, ovf_count_ff};
            mul_b = {9'd0, ovf_ticks_ff};
         end
         MUL_PROP: begin
            mul_a = 33'(err_ff);
            mul_b = {1'b0, gain_prop_ff};
         end
         MUL_INT: begin
            mul_a = 33'(sum_ff);
            mul_b = {1'b0, gain_int_ff};
         end
         MUL_DER: begin
            mul_a = 33'(diff_ff);
            mul_b = {1'b0, gain_der_ff};
         end
         MUL_SCALE: begin
            // the product is only used when 0 < acc < 1.0, so the low bits are the whole value
            mul_a = 33'(acc_ff[OUT_SHIFT-1:0]);
            mul_b = {9'd0, pwm_top_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Period: count*ticks fits 32 bits, plus capture never wraps
   assign period_in = prod_ff[31:0] + {16'd0, cap_ff};

   // Restoring divider step
   assign trial = {1'b0, rem_ff, quo_ff[23]} - {2'b00, period_ff};

   // Error terms with saturating sum
   assign err_w  = $signed({1'b0, speed_now_ff}) - $signed({1'b0, desired_ff});
   assign sum_w  = 33'(err_sum_ff) + 33'(err_w);
   assign diff_w = 18'(err_w) - 18'(last_err_ff);

   always_comb begin
      if (sum_w[32] != sum_w[31]) begin
         sum_sat = sum_w[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         sum_sat = sum_w[31:0];
      end
   end

   // Accumulator
   always_comb begin
      acc_in = acc_ff;
      if (cmd.err_calc) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + 59'(prod_ff);
      end
   end

   // Speed from quotient, saturated
   always_comb begin
      if (sts.period_zero || (|quo_ff[23:16])) begin
         speed_calc = 16'hFFFF;
      end else begin
         speed_calc = quo_ff[15:0];
      end
   end

   // Output clamp and scaling
   assign ge_one  = !acc_ff[58] && (|acc_ff[57:OUT_SHIFT]);
   assign le_zero = acc_ff[58] || (acc_ff == '0);

   always_comb begin
      if (ge_one) begin
         duty_calc = pwm_top_ff;
      end else if (le_zero) begin
         duty_calc = '0;
      end else begin
         duty_calc = prod_ff[OUT_SHIFT+15:OUT_SHIFT];
      end
   end

   // Result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit_cap || cmd.commit_reg) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_count_ff <= '0;
         speed_now_ff <= '0;
         err_sum_ff   <= '0;
         last_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.ovf_inc && (ovf_count_ff != 16'hFFFF)) begin
            ovf_count_ff <= ovf_count_ff + 16'd1;
         end
         if (cmd.commit_cap) begin
            ovf_count_ff <= '0;
            speed_now_ff <= speed_calc;
         end
         if (cmd.commit_reg) begin
            err_sum_ff  <= sum_ff;
            last_err_ff <= err_ff;
         end
         if (cmd.div_init) begin
            cnt_ff <= DIV_CNT_W'(DIV_STEPS);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cap_ff <= req_capture_count;
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.period_load) begin
         period_ff <= period_in;
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= numer_ff;
      end else if (cmd.div_step) begin
         if (!trial[33]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[22:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[23]};
            quo_ff <= {quo_ff[22:0], 1'b0};
         end
      end
      if (cmd.err_calc) begin
         err_ff  <= err_w;
         sum_ff  <= sum_sat;
         diff_ff <= diff_w;
      end
      acc_ff <= acc_in;
      if (cmd.commit_cap) begin
         rsp_kind_ff   <= RK_SPEED;
         rsp_period_ff <= period_ff;
         rsp_speed_ff  <= speed_calc;
         rsp_zero_ff   <= sts.period_zero;
         rsp_duty_ff   <= '0;
      end else if (cmd.commit_reg) begin
         rsp_kind_ff   <= RK_DUTY;
         rsp_period_ff <= '0;
         rsp_speed_ff  <= '0;
         rsp_zero_ff   <= 1'b0;
         rsp_duty_ff   <= duty_calc;
      end
   end

   // Status to controller
   assign sts.period_zero = (period_ff == '0);
   assign sts.div_last    = (cnt_ff == DIV_CNT_W'(1));
   assign sts.rsp_busy    = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_speed_value  = rsp_speed_ff;
   assign rsp_zero_period  = rsp_zero_ff;
   assign rsp_duty_compare = rsp_duty_ff;

endmodule

/* sv/wheel_speed_pid_duty.sv */
// Top level: wheel speed measurement and PID duty regulator.
// Overflow item: taken without leaving idle, no result; next item the following cycle.
// Capture item: speed result; multiply, add, then 1-bit/cycle divider, skipped if period is 0.
// Regulator item: duty result (shared multiplier used 4 times).
// One item at a time; the next is taken once the sequence returns to idle.
// Synchronous reset restores configuration defaults and clears block state; payload registers are not reset.
module wheel_speed_pid_duty import wsp_pkg::*; #(
   parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [15:0]            req_capture_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [31:0]            rsp_period_ticks,
   output logic [15:0]            rsp_speed_value,
   output logic                   rsp_zero_period,
   output logic [15:0]            rsp_duty_compare
);

   wsp_cmd_type cmd;
   wsp_sts_type sts;

   // Sequencer
   wsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and storage
   wsp_dp #(
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_capture_count (req_capture_count),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_period_ticks  (rsp_period_ticks),
      .rsp_speed_value   (rsp_speed_value),
      .rsp_zero_period   (rsp_zero_period),
      .rsp_duty_compare  (rsp_duty_compare)
   );

endmodule

/* dv/wsp_checker.sv */
`timescale 1ns / 100ps
// Checker: mirrors the wheel speed PID duty block and compares every result it emits.
module wsp_checker import wsp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [15:0]            req_capture_count,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_result_kind,
   input  logic [31:0]            rsp_period_ticks,
   input  logic [15:0]            rsp_speed_value,
   input  logic                   rsp_zero_period,
   input  logic [15:0]            rsp_duty_compare,
   output int                     error_count,
   output int                     pending_count,
   output int                     compared_count
);

   localparam int     OUT_SHIFT = SPEED_FRAC_BITS_DEF + 16;
   localparam longint OUT_ONE   = longint'(1) << OUT_SHIFT;
   localparam longint SUM_MAX   = 2147483647;
   localparam longint SUM_MIN   = -SUM_MAX - 1;

   typedef struct {
      logic        kind;
      logic [31:0] period;
      logic [15:0] speed;
      logic        zero;
      logic [15:0] duty;
   } wheel_report_type;

   // results predicted but not yet seen, oldest first
   wheel_report_type wheel_reports[$];

   // mirrored configuration
   logic [15:0] desired_speed;
   logic [23:0] gain_prop;
   logic [23:0] gain_int_dt;
   logic [23:0] gain_der_per_dt;
   logic [23:0] speed_numerator;
   logic [15:0] overflow_ticks;
   logic [15:0] pwm_top;

   // mirrored controller state
   logic [15:0]        ovf_count;
   logic [15:0]        speed_now;
   logic signed [31:0] err_sum;
   logic signed [16:0] last_err;

   int fail_total;
   int compared_total;

   // Advance the mirror by one event; returns 1 when the event yields a result
   function automatic bit predict_event(input logic [1:0] op, input logic [15:0] cap,
                                        output wheel_report_type rpt);
      longint a, b, c, period, quot;
      longint spd, tgt, err, sum, diff, kp, ki, kd, acc, top, scaled;
      rpt = '{default: '0};
      case (op)
         OP_OVERFLOW: begin
            if (ovf_count != 16'hFFFF) ovf_count = ovf_count + 16'd1;
            return 1'b0;
         end
         OP_CAPTURE: begin
            a = ovf_count;
            b = overflow_ticks;
            c = cap;
            period = a * b + c;
            rpt.kind   = RK_SPEED;
            rpt.period = period[31:0];
            if (period == 0) begin
               rpt.speed = 16'hFFFF;
               rpt.zero  = 1'b1;
            end else begin
               quot = speed_numerator;
               quot = quot / period;
               rpt.speed = (quot > 65535) ? 16'hFFFF : quot[15:0];
            end
            speed_now = rpt.speed;
            ovf_count = '0;
            return 1'b1;
         end
         OP_REGULATE: begin
            spd = speed_now;
            tgt = desired_speed;
            err = spd - tgt;
            sum = err_sum;
            sum = sum + err;
            if (sum > SUM_MAX) sum = SUM_MAX;
            else if (sum < SUM_MIN) sum = SUM_MIN;
            diff = last_err;
            diff = err - diff;
            kp = gain_prop;
            ki = gain_int_dt;
            kd = gain_der_per_dt;
            acc = kp * err + ki * sum + kd * diff;
            top = pwm_top;
            rpt.kind = RK_DUTY;
            if (acc >= OUT_ONE) begin
               rpt.duty = pwm_top;
            end else if (acc <= 0) begin
               rpt.duty = '0;
            end else begin
               scaled = (acc * top) >>> OUT_SHIFT;
               rpt.duty = scaled[15:0];
            end
            err_sum  = sum[31:0];
            last_err = err[16:0];
            return 1'b1;
         end
         default: return 1'b0;  // unused code, nothing changes
      endcase
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         if (fail_total < 10)
            $display("MISMATCH result %0d %s: expected 0x%0h, actual 0x%0h",
                     compared_total, field, want, got);
         fail_total++;
      end
   endtask

   // Sample both channels and the register port on each edge
   always @(posedge clock) begin
      wheel_report_type want;
      wheel_report_type fresh;
      if (reset) begin
         desired_speed   = DESIRED_SPEED_RST;
         gain_prop       = GAIN_PROP_RST;
         gain_int_dt     = GAIN_INT_DT_RST;
         gain_der_per_dt = GAIN_DER_PER_DT_RST;
         speed_numerator = SPEED_NUMERATOR_RST;
         overflow_ticks  = OVERFLOW_TICKS_RST;
         pwm_top         = PWM_TOP_RST;
         ovf_count       = '0;
         speed_now       = '0;
         err_sum         = '0;
         last_err        = '0;
         wheel_reports.delete();
      end else begin
         // result side first: it belongs to an earlier item
         if (rsp_valid && !rsp_stall) begin
            compared_total++;
            if (wheel_reports.size() == 0) begin
               if (fail_total < 10)
                  $display("MISMATCH result %0d arrived with nothing predicted (kind %0b)",
                           compared_total, rsp_result_kind);
               fail_total++;
            end else begin
               want = wheel_reports.pop_front();
               check_field("result_kind",  32'(want.kind),   32'(rsp_result_kind));
               check_field("period_ticks", want.period,      rsp_period_ticks);
               check_field("speed_value",  32'(want.speed),  32'(rsp_speed_value));
               check_field("zero_period",  32'(want.zero),   32'(rsp_zero_period));
               check_field("duty_compare", 32'(want.duty),   32'(rsp_duty_compare));
            end
         end
         // register writes; out-of-range indexes are dropped
         if (csr_write) begin
            case (csr_index)
               CSR_DESIRED_SPEED:   desired_speed   = csr_wdata[15:0];
               CSR_GAIN_PROP:       gain_prop       = csr_wdata;
               CSR_GAIN_INT_DT:     gain_int_dt     = csr_wdata;
               CSR_GAIN_DER_PER_DT: gain_der_per_dt = csr_wdata;
               CSR_SPEED_NUMERATOR: speed_numerator = csr_wdata;
               CSR_OVERFLOW_TICKS:  overflow_ticks  = csr_wdata[15:0];
               CSR_PWM_TOP:         pwm_top         = csr_wdata[15:0];
               default: ;
            endcase
         end
         // accepted item
         if (req_valid && !req_stall) begin
            if (predict_event(req_op, req_capture_count, fresh))
               wheel_reports.push_back(fresh);
         end
      end
      error_count    <= fail_total;
      pending_count  <= wheel_reports.size();
      compared_count <= compared_total;
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Testbench top: drives events and register settings into the wheel speed PID duty block.
module testbench import wsp_pkg::*; ();

   localparam int              CYCLE_LIMIT   = 4000000;
   localparam int              SETTLE_CYCLES = 40;
   localparam logic [1:0]      OP_UNUSED     = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   csr_write         = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata         = '0;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_op            = OP_OVERFLOW;
   logic [15:0]            req_capture_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic                   rsp_result_kind;
   logic [31:0]            rsp_period_ticks;
   logic [15:0]            rsp_speed_value;
   logic                   rsp_zero_period;
   logic [15:0]            rsp_duty_compare;

   int fail_count, pending_count, compared_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int n_capture, n_overflow, n_regulate, n_unused, n_settings;

   wheel_speed_pid_duty u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_capture_count (req_capture_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_period_ticks  (rsp_period_ticks),
      .rsp_speed_value   (rsp_speed_value),
      .rsp_zero_period   (rsp_zero_period),
      .rsp_duty_compare  (rsp_duty_compare)
   );

   wsp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_capture_count (req_capture_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_period_ticks  (rsp_period_ticks),
      .rsp_speed_value   (rsp_speed_value),
      .rsp_zero_period   (rsp_zero_period),
      .rsp_duty_compare  (rsp_duty_compare),
      .error_count       (fail_count),
      .pending_count     (pending_count),
      .compared_count    (compared_count)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // run-length guard
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // Offer one item, with a random gap first; valid stays high for the next item
   task automatic send_item(input logic [1:0] op, input logic [15:0] cap);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_capture_count <= cap;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (op)
         OP_CAPTURE:  n_capture++;
         OP_OVERFLOW: n_overflow++;
         OP_REGULATE: n_regulate++;
         default:     n_unused++;
      endcase
   endtask

   // Hold off the sender until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Idle point: drained, plus time for a result-less item to finish
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_write high; program_regs lowers it after the last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Full register set; 16-bit registers get junk in the upper byte to check masking
   task automatic program_regs(input logic [15:0] desired, input logic [23:0] kp,
                               input logic [23:0] ki, input logic [23:0] kd,
                               input logic [23:0] num, input logic [15:0] ticks,
                               input logic [15:0] top);
      write_reg(CSR_DESIRED_SPEED,   {8'($urandom), desired});
      write_reg(CSR_GAIN_PROP,       kp);
      write_reg(CSR_GAIN_INT_DT,     ki);
      write_reg(CSR_GAIN_DER_PER_DT, kd);
      write_reg(CSR_SPEED_NUMERATOR, num);
      write_reg(CSR_OVERFLOW_TICKS,  {8'($urandom), ticks});
      write_reg(CSR_PWM_TOP,         {8'($urandom), top});
      write_reg(CSR_SPARE,           24'($urandom));
      csr_write <= 1'b0;
      n_settings++;
   endtask

   // Mostly runs of up to three overflows, a capture and one to three regulates, some noise
   task automatic run_random(input int target);
      int          done, n;
      bit          paused;
      logic [1:0]  op;
      logic [15:0] cap;
      done   = 0;
      paused = 1'b0;
      while (done < target) begin
         if ($urandom_range(0, 99) < 12) begin
            op = 2'($urandom);
            send_item(op, 16'($urandom));
            if (op != OP_UNUSED) done++;
         end else begin
            n = $urandom_range(0, 3);
            repeat (n) begin
               send_item(OP_OVERFLOW, 16'($urandom));
               done++;
            end
            case ($urandom_range(0, 3))
               0:       cap = 16'($urandom_range(0, 15));
               1:       cap = 16'($urandom_range(65520, 65535));
               default: cap = 16'($urandom);
            endcase
            send_item(OP_CAPTURE, cap);
            done++;
            n = $urandom_range(1, 3);
            repeat (n) begin
               send_item(OP_REGULATE, 16'($urandom));
               done++;
            end
         end
         // sender pause until the block is empty
         if ((!paused && done >= target / 2) || $urandom_range(0, 99) < 3) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   task automatic random_regs();
      program_regs(16'($urandom), 24'($urandom_range(0, 262143)),
                   24'($urandom_range(0, 4095)), 24'($urandom_range(0, 1048575)),
                   24'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Main stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed items on reset defaults
      send_idle_pct = 38;
      recv_idle_pct = 61;
      send_item(OP_REGULATE, 16'h0000);     // zero error
      send_item(OP_CAPTURE,  16'h0000);     // zero period
      send_item(OP_REGULATE, 16'hFFFF);     // output clamps high
      send_item(OP_UNUSED,   16'hA5A5);     // ignored
      repeat (3) send_item(OP_OVERFLOW, 16'h0000);
      send_item(OP_CAPTURE,  16'hFFFF);
      send_item(OP_REGULATE, 16'h0000);     // large negative difference
      send_item(OP_REGULATE, 16'h0000);
      send_item(OP_CAPTURE,  16'h0001);     // speed saturates
      send_item(OP_CAPTURE,  16'hFFFF);
      send_item(OP_REGULATE, 16'h5A5A);

      // zero numerator, zero overflow period, zero PWM top
      settle();
      program_regs(16'd300, 24'd65536, 24'd393, 24'd1000, 24'd0, 16'd0, 16'd0);
      repeat (2) send_item(OP_OVERFLOW, 16'h0000);
      send_item(OP_CAPTURE,  16'd1000);
      send_item(OP_OVERFLOW, 16'h0000);
      send_item(OP_CAPTURE,  16'h0000);
      send_item(OP_REGULATE, 16'h0000);
      send_item(OP_UNUSED,   16'h0000);

      // long overflow run at the widest overflow period
      settle();
      program_regs(16'd0, GAIN_PROP_RST, GAIN_INT_DT_RST, GAIN_DER_PER_DT_RST,
                   24'hFFFFFF, 16'hFFFF, PWM_TOP_RST);
      repeat (40) send_item(OP_OVERFLOW, 16'($urandom));
      send_item(OP_CAPTURE, 16'hFFFF);
      send_item(OP_CAPTURE, 16'h0000);

      // grow the error sum with the speed at maximum
      settle();
      program_regs(16'd0, 24'd0, 24'd0, 24'd0, SPEED_NUMERATOR_RST, OVERFLOW_TICKS_RST,
                   16'hFFFF);
      send_item(OP_CAPTURE, 16'h0000);      // speed at maximum
      repeat (40) send_item(OP_REGULATE, 16'h0000);
      // large negative error pulling the accumulated sum back down
      settle();
      program_regs(16'hFFFF, 24'd32767, 24'd1, 24'd0, 24'd1, OVERFLOW_TICKS_RST, 16'hFFFF);
      send_item(OP_CAPTURE, 16'h0002);      // speed zero
      repeat (4) send_item(OP_REGULATE, 16'h0000);

      // random traffic: receiver idles more than sender
      settle();
      send_idle_pct = 38;
      recv_idle_pct = 61;
      random_regs();
      run_random(230);

      // sender idles more; first all registers at maximum, then random
      settle();
      send_idle_pct = 61;
      recv_idle_pct = 38;
      program_regs(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
                   16'hFFFF);
      run_random(110);
      settle();
      random_regs();
      run_random(110);

      // no idling; smallest legal settings with a random proportional gain, then random
      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(16'd0, 24'($urandom_range(0, 65535)), 24'd1, 24'd1, 24'd1, 16'd1, 16'd1);
      run_random(110);
      settle();
      random_regs();
      run_random(130);

      settle();
      $display("Summary: %0d capture, %0d overflow, %0d regulator, %0d unused-code items",
               n_capture, n_overflow, n_regulate, n_unused);
      $display("Summary: %0d results compared over %0d register settings",
               compared_count, n_settings);
      if (pending_count != 0)
         $display("%0d predicted results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
sv/wsp_pkg.sv
sv/wsp_ctrl.sv
sv/wsp_dp.sv
sv/wheel_speed_pid_duty.sv
dv/wsp_checker.sv
dv/testbench.sv
